### rtl/dfrt_pkg.sv
// Shared constants, types and command structures of the duplicate frame rejection table.
`default_nettype none

package dfrt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W     = 16;
    localparam int SEQ_W      = 8;
    localparam int LIFE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIFETIME = 1'b1;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd10;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_INSERT,
        ST_AGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic own_reject;
        logic scan_step;
        logic insert;
        logic age_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic tick;
        logic own_match;
        logic hit;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/dfrt_ctrl.sv
// Controller state machine sequencing the table scan for frames and ticks.
`default_nettype none

module dfrt_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire dfrt_pkg::t_dp_status i_status,
    output dfrt_pkg::t_dp_cmd         o_cmd
);

    dfrt_pkg::t_state r_state;
    dfrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dfrt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dfrt_pkg::ST_CHECK;
                end
            end
            dfrt_pkg::ST_CHECK: begin
                priority if (i_status.tick) begin
                    n_state = dfrt_pkg::ST_AGE;
                end else if (i_status.own_match) begin
                    n_state = dfrt_pkg::ST_EMIT;
                end else begin
                    n_state = dfrt_pkg::ST_SCAN;
                end
            end
            dfrt_pkg::ST_SCAN: begin
                priority if (i_status.hit) begin
                    n_state = dfrt_pkg::ST_EMIT;
                end else if (i_status.last) begin
                    n_state = dfrt_pkg::ST_INSERT;
                end
            end
            dfrt_pkg::ST_INSERT: begin
                n_state = dfrt_pkg::ST_EMIT;
            end
            dfrt_pkg::ST_AGE: begin
                if (i_status.last) begin
                    n_state = dfrt_pkg::ST_EMIT;
                end
            end
            dfrt_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = dfrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dfrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dfrt_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            dfrt_pkg::ST_CHECK: begin
                o_cmd.own_reject = !i_status.tick && i_status.own_match;
            end
            dfrt_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            dfrt_pkg::ST_INSERT: begin
                o_cmd.insert = 1'b1;
            end
            dfrt_pkg::ST_AGE: begin
                o_cmd.age_step = 1'b1;
            end
            dfrt_pkg::ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/dfrt_datapath.sv
// Datapath: captured item, entry table, scan index, configuration and result register.
`default_nettype none

module dfrt_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire dfrt_pkg::t_dp_cmd              i_cmd,
    output dfrt_pkg::t_dp_status                o_status,
    input  wire                                 i_func,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_source_address,
    input  wire  [dfrt_pkg::SEQ_W-1:0]          i_sequence_number,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_link_destination,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_network_destination,
    input  wire                                 i_cfg_valid,
    input  wire  [dfrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [dfrt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_reject,
    output logic                                o_route_remove_valid,
    output logic [dfrt_pkg::ADDR_W-1:0]         o_route_remove_address
);

    logic                          r_func;
    logic [dfrt_pkg::ADDR_W-1:0]   r_src;
    logic [dfrt_pkg::SEQ_W-1:0]    r_seq;
    logic [dfrt_pkg::ADDR_W-1:0]   r_link;
    logic [dfrt_pkg::ADDR_W-1:0]   r_net;

    dfrt_pkg::t_idx                r_idx;
    logic                          r_free_found;
    dfrt_pkg::t_idx                r_free_idx;

    logic                          r_pend_reject;
    logic                          r_pend_rmv;
    logic [dfrt_pkg::ADDR_W-1:0]   r_pend_addr;

    logic                          r_out_valid;
    logic                          r_out_reject;
    logic                          r_out_rmv;
    logic [dfrt_pkg::ADDR_W-1:0]   r_out_addr;

    logic [dfrt_pkg::ADDR_W-1:0]   r_own_address;
    logic [dfrt_pkg::LIFE_W-1:0]   r_entry_lifetime;

    logic [dfrt_pkg::ADDR_W-1:0]   r_src_tab  [dfrt_pkg::TABLE_ENTRIES];
    logic [dfrt_pkg::SEQ_W-1:0]    r_seq_tab  [dfrt_pkg::TABLE_ENTRIES];
    logic [dfrt_pkg::LIFE_W-1:0]   r_life_tab [dfrt_pkg::TABLE_ENTRIES];

    logic                          live;
    logic                          match;
    logic [dfrt_pkg::SEQ_W-1:0]    diff;
    logic                          seq_ok;
    logic                          rmv;
    logic                          last;

    always_comb begin
        live   = r_life_tab[r_idx] != '0;
        match  = live && (r_src_tab[r_idx] == r_src);
        diff   = r_seq - r_seq_tab[r_idx];
        seq_ok = (diff != '0) && !diff[dfrt_pkg::SEQ_W-1];
        rmv    = r_own_address == r_link;
        last   = r_idx == dfrt_pkg::IDX_W'(dfrt_pkg::TABLE_ENTRIES - 1);
    end

    always_comb begin
        o_status.tick      = r_func;
        o_status.own_match = r_src == r_own_address;
        o_status.hit       = match;
        o_status.last      = last;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_src  <= i_source_address;
            r_seq  <= i_sequence_number;
            r_link <= i_link_destination;
            r_net  <= i_network_destination;
        end
    end

    // advance scan index, remember the highest free entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else begin
            priority if (i_cmd.capture) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.age_step) begin
                if (!last) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (i_cmd.scan_step && !live) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.capture) begin
            r_pend_reject <= 1'b0;
            r_pend_rmv    <= 1'b0;
            r_pend_addr   <= '0;
        end else if (i_cmd.own_reject) begin
            r_pend_reject <= 1'b1;
        end else if (i_cmd.scan_step && match && !seq_ok) begin
            r_pend_reject <= 1'b1;
            r_pend_rmv    <= rmv;
            r_pend_addr   <= rmv ? r_net : '0;
        end else if (i_cmd.insert && !r_free_found) begin
            r_pend_reject <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dfrt_pkg::TABLE_ENTRIES; k++) begin
                r_life_tab[k] <= '0;
            end
        end else begin
            priority if (i_cmd.age_step) begin
                if (live) begin
                    r_life_tab[r_idx] <= r_life_tab[r_idx] - 1'b1;
                end
            end else if (i_cmd.scan_step && match && seq_ok) begin
                r_life_tab[r_idx] <= r_entry_lifetime;
            end else if (i_cmd.insert && r_free_found) begin
                r_life_tab[r_free_idx] <= r_entry_lifetime;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.scan_step && match && seq_ok) begin
            r_seq_tab[r_idx] <= r_seq;
        end else if (i_cmd.insert && r_free_found) begin
            r_src_tab[r_free_idx] <= r_src;
            r_seq_tab[r_free_idx] <= r_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address    <= '0;
            r_entry_lifetime <= dfrt_pkg::LIFETIME_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dfrt_pkg::CFG_OWN_ADDRESS: begin
                    r_own_address <= i_cfg_data;
                end
                dfrt_pkg::CFG_ENTRY_LIFETIME: begin
                    r_entry_lifetime <= i_cfg_data[dfrt_pkg::LIFE_W-1:0];
                end
                default: begin
                    r_own_address <= r_own_address;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_reject <= r_pend_reject;
            r_out_rmv    <= r_pend_rmv;
            r_out_addr   <= r_pend_addr;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_reject               = r_out_reject;
    assign o_route_remove_valid   = r_out_rmv;
    assign o_route_remove_address = r_out_addr;

endmodule

`default_nettype wire

### rtl/duplicate_frame_rejection_table.sv
// Top level of the duplicate frame rejection table: controller and datapath.
//
// Each input transfer is a received frame header (func 0) or an aging tick (func 1) and yields
// exactly one result. The table of TABLE_ENTRIES entries is held in registers and walked one
// entry per cycle, so the scan sets the rate: a tick ages every live entry, a frame from a new
// source scans every entry and then inserts, a frame from a known source stops at the matching
// entry, and a frame from the own address skips the scan. A finished result waits in an output
// register while the next item is taken. Configuration writes (index 0 own address, index 1
// entry lifetime in ticks) are always ready and must only be issued while the block is idle.
// Entry lifetimes are cleared by reset.
`default_nettype none

module duplicate_frame_rejection_table (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_func,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_source_address,
    input  wire  [dfrt_pkg::SEQ_W-1:0]          i_sequence_number,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_link_destination,
    input  wire  [dfrt_pkg::ADDR_W-1:0]         i_network_destination,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [dfrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [dfrt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_reject,
    output logic                                o_route_remove_valid,
    output logic [dfrt_pkg::ADDR_W-1:0]         o_route_remove_address
);

    dfrt_pkg::t_dp_cmd    cmd;
    dfrt_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    dfrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dfrt_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_func                 (i_func),
        .i_source_address       (i_source_address),
        .i_sequence_number      (i_sequence_number),
        .i_link_destination     (i_link_destination),
        .i_network_destination  (i_network_destination),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_out_ready            (i_out_ready),
        .o_out_valid            (o_out_valid),
        .o_reject               (o_reject),
        .o_route_remove_valid   (o_route_remove_valid),
        .o_route_remove_address (o_route_remove_address)
    );

endmodule

`default_nettype wire

### rtl/dfrt_checker.sv
// Port-level checker for the duplicate frame rejection table, bound to the top level.
`default_nettype none

module dfrt_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_ready,
    input wire                              o_out_valid,
    input wire                              i_out_ready,
    input wire                              o_reject,
    input wire                              o_route_remove_valid,
    input wire [dfrt_pkg::ADDR_W-1:0]       o_route_remove_address
);

    // one item at a time: ready drops after an input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_remove_implies_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_route_remove_valid |-> o_reject)
        else $error("route removal requested for an accepted frame");

    a_address_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_route_remove_valid |-> o_route_remove_address == '0)
        else $error("route removal address set without a request");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_reject)
            && $stable(o_route_remove_valid) && $stable(o_route_remove_address))
        else $error("stalled result changed");

endmodule

bind duplicate_frame_rejection_table dfrt_checker u_dfrt_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_in_valid),
    .o_in_ready             (o_in_ready),
    .o_out_valid            (o_out_valid),
    .i_out_ready            (i_out_ready),
    .o_reject               (o_reject),
    .o_route_remove_valid   (o_route_remove_valid),
    .o_route_remove_address (o_route_remove_address)
);

`default_nettype wire
